// ----- rtl/core/tcbw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcbw_pkg
// Shared types, constants and attribute helpers for the text cell buffer
// writer: operation and register codes, beat payloads, memory port structs.
// ----------------------------------------------------------------------------
package tcbw_pkg;

   // Cell store geometry
   localparam int CELL_COUNT = 8192;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = ADDR_W + 1;
   // Address arithmetic: row * columns + column can reach 63*255 + 255
   localparam int CALC_W     = 15;
   localparam int CELL_W     = 16;

   localparam logic [CALC_W-1:0] CELL_LIMIT = CALC_W'(CELL_COUNT);

   // Operation codes
   localparam logic [2:0] OP_PUT        = 3'd0;
   localparam logic [2:0] OP_MOVE       = 3'd1;
   localparam logic [2:0] OP_ERASE_LINE = 3'd2;
   localparam logic [2:0] OP_ERASE_PAGE = 3'd3;
   localparam logic [2:0] OP_FLUSH      = 3'd4;
   localparam logic [2:0] OP_READ       = 3'd5;

   // Register indexes
   localparam logic [2:0] REG_COLUMNS   = 3'd0;
   localparam logic [2:0] REG_ROWS      = 3'd1;
   localparam logic [2:0] REG_MONO      = 3'd2;
   localparam logic [2:0] REG_FORE      = 3'd3;
   localparam logic [2:0] REG_BACK      = 3'd4;
   localparam logic [2:0] REG_REVERSE   = 3'd5;
   localparam logic [2:0] REG_PAGE_FORE = 3'd6;
   localparam logic [2:0] REG_PAGE_BACK = 3'd7;

   // Character codes
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [3:0] MONO_FORE = 4'h7;
   localparam logic [3:0] MONO_BACK = 4'h0;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] char_code;
      logic [5:0] row;
      logic [6:0] col;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              span_valid;
      logic [ADDR_W-1:0] span_first;
      logic [CNT_W-1:0]  span_count;
      logic [5:0]        cursor_row_out;
      logic [7:0]        cursor_col_out;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   function automatic logic [3:0] ansi_to_ibm(input logic [3:0] idx);
      logic [3:0] res;
      case (idx)
         4'd0:    res = 4'd0;
         4'd1:    res = 4'd4;
         4'd2:    res = 4'd2;
         4'd3:    res = 4'd6;
         4'd4:    res = 4'd1;
         4'd5:    res = 4'd5;
         4'd6:    res = 4'd3;
         4'd7:    res = 4'd7;
         4'd8:    res = 4'd8;
         4'd9:    res = 4'd12;
         4'd10:   res = 4'd10;
         4'd11:   res = 4'd14;
         4'd12:   res = 4'd9;
         4'd13:   res = 4'd13;
         4'd14:   res = 4'd11;
         default: res = 4'd15;
      endcase
      return res;
   endfunction

   // Attribute for put and erase line
   function automatic logic [7:0] text_attr(input logic mono, input logic rev,
                                            input logic [3:0] fore,
                                            input logic [3:0] back);
      logic [3:0] fg;
      logic [3:0] bg;
      fg = mono ? MONO_FORE : ansi_to_ibm(fore);
      bg = mono ? MONO_BACK : ansi_to_ibm(back);
      return rev ? {fg, bg} : {bg, fg};
   endfunction

   // Attribute for erase page; reverse video does not apply
   function automatic logic [7:0] page_attr(input logic mono, input logic [3:0] fore,
                                            input logic [3:0] back);
      logic [7:0] res;
      res = mono ? {MONO_BACK, MONO_FORE} : {ansi_to_ibm(back), ansi_to_ibm(fore)};
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/text_cell_buffer_writer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_buffer_writer_top
// Text-mode cell buffer with cursor, erase fills and changed-span tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on req_item when start is high and busy is low. Every
//   command gives exactly one beat on rsp_item, marked by rsp_strobe for a
//   single cycle; the receiver cannot stall it.
//   Put, move, flush and read: the response follows in the cycle after the
//   command, and busy stays low, so one command per cycle is taken.
//   Read data comes from the cell memory's registered read port.
//   Erase line / erase page: busy stays high while the in-range cells are filled,
//   one memory write per cycle; the response shows in the cycle busy falls,
//   and a new command may enter in that cycle. The user writes registers on
//   the csr_ port only while the block is idle; the block does not enforce it.
//   Reset (synchronous) clears the cursor, empties the changed span and
//   loads the register defaults; cell contents are not cleared and no
//   clearing pass runs, so commands are taken from the first cycle after.
// ----------------------------------------------------------------------------
module text_cell_buffer_writer_top
   import tcbw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output      logic       busy,
   input  wire req_type    req_item,
   output      logic       rsp_strobe,
   output      rsp_type    rsp_item,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FILL = 1'b1;

   logic              state_ff, state_in;
   logic [5:0]        cur_row_ff, cur_row_in;
   logic [7:0]        cur_col_ff, cur_col_in;
   logic [CNT_W-1:0]  dirty_low_ff, dirty_low_in;
   logic [ADDR_W-1:0] dirty_high_ff, dirty_high_in;

   logic [7:0]        columns_ff;
   logic [6:0]        rows_ff;
   logic              mono_ff;
   logic [3:0]        fore_ff;
   logic [3:0]        back_ff;
   logic              rev_ff;
   logic [3:0]        pfore_ff;
   logic [3:0]        pback_ff;

   logic [CALC_W-1:0] fill_idx_ff, fill_idx_in;
   logic [CNT_W-1:0]  fill_end_ff, fill_end_in;
   logic [CELL_W-1:0] fill_val_ff, fill_val_in;
   logic              fill_bad_ff, fill_bad_in;

   rsp_type           rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rd_hit_ff, rd_hit_in;

   mem_wr_type        mem_wr;
   mem_rd_type        mem_rd;
   logic [CELL_W-1:0] mem_q;

   logic              accept;
   logic [CNT_W-1:0]  base;
   logic [CALC_W-1:0] cur_addr;
   logic [7:0]        col_dec;
   logic [CALC_W-1:0] bs_addr;
   logic              is_nl;
   logic              is_bs;
   logic              put_write;
   logic [CALC_W-1:0] put_addr;
   logic              put_in_range;
   logic [7:0]        attr;
   logic [CALC_W-1:0] rd_addr;
   logic              rd_in_range;
   logic [CALC_W-1:0] line_end;
   logic [CALC_W-1:0] page_end;
   logic [CALC_W-1:0] erase_end;
   logic              fill_go;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start & ~busy;
   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      rsp_item            = rsp_ff;
      rsp_item.cell_value = rd_hit_ff ? mem_q : '0;
   end

   // --- address arithmetic ---------------------------------------------
   assign base     = {8'd0, cur_row_ff} * {6'd0, columns_ff};
   assign cur_addr = {1'b0, base} + {7'd0, cur_col_ff};
   assign col_dec  = cur_col_ff - 8'd1;
   assign bs_addr  = {1'b0, base} + {7'd0, col_dec};

   assign is_nl        = (req_item.char_code == CHAR_LF) || (req_item.char_code == CHAR_CR);
   assign is_bs        = (req_item.char_code == CHAR_BS);
   assign put_write    = (req_item.operation == OP_PUT) && !is_nl
                         && !(is_bs && (cur_col_ff == 8'd0));
   assign put_addr     = is_bs ? bs_addr : cur_addr;
   assign put_in_range = (put_addr < CELL_LIMIT);
   assign attr         = text_attr(mono_ff, rev_ff, fore_ff, back_ff);

   assign rd_addr     = {1'b0, {8'd0, req_item.row} * {6'd0, columns_ff}}
                        + {8'd0, req_item.col};
   assign rd_in_range = (rd_addr < CELL_LIMIT);

   assign line_end  = {1'b0, base} + {7'd0, columns_ff};
   assign page_end  = {8'd0, rows_ff} * {7'd0, columns_ff};
   assign erase_end = (req_item.operation == OP_ERASE_LINE) ? line_end : page_end;

   assign fill_go = (state_ff == ST_FILL) && (fill_idx_ff < {1'b0, fill_end_ff});

   // --- memory ports ---------------------------------------------------
   always_comb begin
      mem_wr.en   = 1'b0;
      mem_wr.addr = put_addr[ADDR_W-1:0];
      mem_wr.data = {attr, is_bs ? CHAR_SPACE : req_item.char_code};
      if (state_ff == ST_FILL) begin
         mem_wr.en   = fill_go;
         mem_wr.addr = fill_idx_ff[ADDR_W-1:0];
         mem_wr.data = fill_val_ff;
      end else begin
         mem_wr.en = accept && put_write && put_in_range;
      end
      mem_rd.en   = accept && (req_item.operation == OP_READ) && rd_in_range;
      mem_rd.addr = rd_addr[ADDR_W-1:0];
   end

   tcbw_cell_mem u_cell_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_q)
   );

   // --- command sequencing ---------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      dirty_low_in  = dirty_low_ff;
      dirty_high_in = dirty_high_ff;
      fill_idx_in   = fill_idx_ff;
      fill_end_in   = fill_end_ff;
      fill_val_in   = fill_val_ff;
      fill_bad_in   = fill_bad_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_hit_in     = rd_hit_ff;

      // one writer per cycle, so at most one address is merged into the span
      if (mem_wr.en) begin
         if ({1'b0, mem_wr.addr} < dirty_low_ff) begin
            dirty_low_in = {1'b0, mem_wr.addr};
         end
         if (mem_wr.addr > dirty_high_ff) begin
            dirty_high_in = mem_wr.addr;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in            = '0;
               rd_hit_in         = 1'b0;
               rsp_strobe_in     = 1'b1;
               case (req_item.operation) inside
                  OP_PUT: begin
                     rsp_in.status = put_write && !put_in_range;
                     if (put_write) begin
                        cur_col_in = is_bs ? col_dec : cur_col_ff + 8'd1;
                     end
                  end
                  OP_MOVE: begin
                     cur_row_in = req_item.row;
                     cur_col_in = {1'b0, req_item.col};
                  end
                  OP_ERASE_LINE, OP_ERASE_PAGE: begin
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_FILL;
                     fill_idx_in   = cur_addr;
                     // cells past the store are skipped but flagged
                     fill_bad_in   = (cur_addr < erase_end) && (erase_end > CELL_LIMIT);
                     fill_end_in   = (erase_end > CELL_LIMIT) ? CNT_W'(CELL_COUNT)
                                                              : erase_end[CNT_W-1:0];
                     fill_val_in   = (req_item.operation == OP_ERASE_LINE)
                                     ? {attr, CHAR_SPACE}
                                     : {page_attr(mono_ff, pfore_ff, pback_ff), CHAR_SPACE};
                  end
                  OP_FLUSH: begin
                     if (dirty_low_ff <= {1'b0, dirty_high_ff}) begin
                        rsp_in.span_valid = 1'b1;
                        rsp_in.span_first = dirty_low_ff[ADDR_W-1:0];
                        rsp_in.span_count = {1'b0, dirty_high_ff} - dirty_low_ff
                                            + CNT_W'(1);
                     end
                     dirty_low_in  = CNT_W'(CELL_COUNT);
                     dirty_high_in = '0;
                  end
                  OP_READ: begin
                     rsp_in.status = !rd_in_range;
                     rd_hit_in     = rd_in_range;
                  end
                  default: begin
                  end
               endcase
               rsp_in.cursor_row_out = cur_row_in;
               rsp_in.cursor_col_out = cur_col_in;
            end
         end
         ST_FILL: begin
            if (fill_go) begin
               fill_idx_in = fill_idx_ff + CALC_W'(1);
            end else begin
               state_in              = ST_IDLE;
               rsp_in                = '0;
               rsp_in.status         = fill_bad_ff;
               rsp_in.cursor_row_out = cur_row_ff;
               rsp_in.cursor_col_out = cur_col_ff;
               rd_hit_in             = 1'b0;
               rsp_strobe_in         = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         dirty_low_ff  <= CNT_W'(CELL_COUNT);
         dirty_high_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_hit_ff     <= 1'b0;
         columns_ff    <= 8'd80;
         rows_ff       <= 7'd50;
         mono_ff       <= 1'b0;
         fore_ff       <= 4'd7;
         back_ff       <= 4'd0;
         rev_ff        <= 1'b0;
         pfore_ff      <= 4'd7;
         pback_ff      <= 4'd0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         dirty_low_ff  <= dirty_low_in;
         dirty_high_ff <= dirty_high_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_hit_ff     <= rd_hit_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_COLUMNS:   columns_ff <= csr_wdata;
               REG_ROWS:      rows_ff    <= csr_wdata[6:0];
               REG_MONO:      mono_ff    <= csr_wdata[0];
               REG_FORE:      fore_ff    <= csr_wdata[3:0];
               REG_BACK:      back_ff    <= csr_wdata[3:0];
               REG_REVERSE:   rev_ff     <= csr_wdata[0];
               REG_PAGE_FORE: pfore_ff   <= csr_wdata[3:0];
               REG_PAGE_BACK: pback_ff   <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff <= fill_idx_in;
      fill_end_ff <= fill_end_in;
      fill_val_ff <= fill_val_in;
      fill_bad_ff <= fill_bad_in;
      rsp_ff      <= rsp_in;
   end

   // --- assertions -------------------------------------------------------
   a_no_beat_mid_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> !rsp_strobe)
      else $error("response beat while erase fill in progress");

   a_single_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.operation != OP_ERASE_LINE)
              && (req_item.operation != OP_ERASE_PAGE)) |=> (rsp_strobe && !busy))
      else $error("short command did not respond in the next cycle");

   a_span_shape: assert property (@(posedge clock) disable iff (reset)
      ((dirty_low_ff == CNT_W'(CELL_COUNT)) && (dirty_high_ff == '0))
      || (dirty_low_ff <= {1'b0, dirty_high_ff}))
      else $error("changed span bounds inconsistent");

   a_fill_in_store: assert property (@(posedge clock) disable iff (reset)
      fill_go |-> (fill_idx_ff < CELL_LIMIT))
      else $error("erase fill write beyond cell store");

endmodule
`default_nettype wire

// ----- rtl/core/tcbw_cell_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcbw_cell_mem
// Character cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcbw_cell_mem
   import tcbw_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_wr_type        wr,
   input  wire mem_rd_type        rd,
   output      logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cells[wr.addr] <= wr.data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= cells[rd.addr];
      end
   end

endmodule
`default_nettype wire
